>>> hw/rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and constants shared by the layered sprite compositor files.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // table geometry
  localparam int MAX_SPRITES    = 16;
  localparam int MAX_SPRITE_DIM = 32;
  localparam int COLOR_BITS     = 8;

  localparam int SPR_W   = $clog2(MAX_SPRITES);
  localparam int DIM_W   = $clog2(MAX_SPRITE_DIM);
  localparam int PLANE_W = 2 * DIM_W;
  localparam int RAM_AW  = SPR_W + PLANE_W;
  localparam int RAM_DEPTH = MAX_SPRITES * MAX_SPRITE_DIM * MAX_SPRITE_DIM;

  // remainder unit works on a 17 bit magnitude, one bit a step
  localparam int MAG_W     = 17;
  localparam int MOD_STEPS = MAG_W;

  // action codes
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_LAYER = 3'd1;
  localparam logic [2:0] ACT_SHOW  = 3'd2;
  localparam logic [2:0] ACT_MOVE  = 3'd3;
  localparam logic [2:0] ACT_WRITE = 3'd4;
  localparam logic [2:0] ACT_QUERY = 3'd5;

  localparam logic [7:0] TRANSP_RESET = 8'd255;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         sprite_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [5:0]         size_w;
    logic [5:0]         size_h;
    logic [7:0]         layer_value;
    logic [1:0]         tile_mode;
    logic [4:0]         pixel_col;
    logic [4:0]         pixel_row;
    logic [7:0]         pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] shown_color;
    logic       covered;
    logic [3:0] winner;
    logic       status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INIT_CLR,
    ST_RM_WALK,
    ST_INS_WALK,
    ST_Q_FETCH,
    ST_Q_MODX,
    ST_Q_MODY,
    ST_Q_CHECK,
    ST_Q_READ,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/layered_sprite_compositor_unit.sv
// ----------------------------------------------------------------------------
// layered_sprite_compositor_unit
// Sprite table with priority list; a query walks the list front first and
// returns the first non-transparent color at a screen point.
// ----------------------------------------------------------------------------
// Init clears the sprite's pixel plane one pixel per cycle; show makes two list
//   walks, a removal walk and then an insertion walk unless the list is full.
// Query: per listed sprite a fetch, then for each tiled axis a pass of the shared
//   bit-serial remainder unit, a range check and, if in range, one pixel memory read.
// One item at a time; the result waits in an output register.
// Reset clears control state and the sprite table, empties the list and sets the
//   transparent code to 255; the pixel memory is not cleared.
// ----------------------------------------------------------------------------
module layered_sprite_compositor_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lsc_pkg::out_item_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  localparam int NS = lsc_pkg::MAX_SPRITES;
  localparam int SW = lsc_pkg::SPR_W;
  localparam int DW = lsc_pkg::DIM_W;
  localparam int MW = lsc_pkg::MAG_W;

  lsc_pkg::state_t    state, state_next;
  lsc_pkg::in_item_t  item;
  lsc_pkg::out_item_t res;
  logic [7:0]         transp;

  // sprite table
  logic [15:0] spr_left   [NS];
  logic [15:0] spr_top    [NS];
  logic [5:0]  spr_width  [NS];
  logic [5:0]  spr_height [NS];
  logic [7:0]  spr_layer  [NS];
  logic [1:0]  spr_tile   [NS];

  // priority list
  logic [SW-1:0] plist [NS];
  logic [SW:0]   count;
  logic [SW:0]   i;
  logic [SW:0]   j;
  logic [SW-1:0] carry;
  logic          inserted;
  logic [7:0]    my_layer;

  // query working registers
  logic [SW-1:0]        cur_t;
  logic [5:0]           cw, ch;
  logic [1:0]           ctile;
  logic signed [MW-1:0] dx, dy;
  logic [MW-1:0]        mag;
  logic                 neg;
  logic [4:0]           rem;
  logic [4:0]           step_cnt;
  logic [lsc_pkg::PLANE_W-1:0] clr_cnt;

  // combinational helpers
  logic [SW-1:0]        list_rd;
  logic [SW-1:0]        attr_addr;
  logic [15:0]          a_left, a_top;
  logic [5:0]           a_w, a_h;
  logic [7:0]           a_layer;
  logic [1:0]           a_tile;
  logic signed [MW-1:0] dx_c, dy_c;
  logic [5:0]           mod_w, r2, r_sub;
  logic [4:0]           rem_step;
  logic [5:0]           mod_fin;
  logic                 mod_last;
  logic [MW-1:0]        abs_dy;
  logic                 in_range;
  logic                 wr_bad;

  logic                           ram_we;
  logic [lsc_pkg::RAM_AW-1:0]     ram_addr;
  logic [lsc_pkg::COLOR_BITS-1:0] ram_wdata;
  logic [lsc_pkg::COLOR_BITS-1:0] ram_rdata;

  logic          list_we;
  logic [SW-1:0] list_waddr;
  logic [SW-1:0] list_wdata;

  lsc_ram #(
    .WIDTH (lsc_pkg::COLOR_BITS),
    .DEPTH (lsc_pkg::RAM_DEPTH)
  ) u_pix (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // table reads
  always_comb begin
    list_rd   = plist[i[SW-1:0]];
    attr_addr = (state == lsc_pkg::ST_Q_FETCH || state == lsc_pkg::ST_INS_WALK) ?
                list_rd : item.sprite_index[SW-1:0];
    a_left  = spr_left[attr_addr];
    a_top   = spr_top[attr_addr];
    a_w     = spr_width[attr_addr];
    a_h     = spr_height[attr_addr];
    a_layer = spr_layer[attr_addr];
    a_tile  = spr_tile[attr_addr];
    dx_c = $signed({item.pos_x[15], item.pos_x}) - $signed({a_left[15], a_left});
    dy_c = $signed({item.pos_y[15], item.pos_y}) - $signed({a_top[15], a_top});
    wr_bad = ({1'b0, item.pixel_col} >= a_w) || ({1'b0, item.pixel_row} >= a_h);
  end

  // shared bit-serial floor remainder unit
  always_comb begin
    mod_w    = (state == lsc_pkg::ST_Q_MODX) ? cw : ch;
    r2       = {rem, mag[MW-1]};
    r_sub    = (r2 >= mod_w) ? (r2 - mod_w) : r2;
    rem_step = r_sub[4:0];
    mod_fin  = (neg && rem_step != 5'd0) ? (mod_w - {1'b0, rem_step})
                                          : {1'b0, rem_step};
    mod_last = (step_cnt == 5'(lsc_pkg::MOD_STEPS - 1));
    abs_dy   = dy[MW-1] ? MW'(-dy) : MW'(dy);
    in_range = !dx[MW-1] && (dx < MW'(cw)) && !dy[MW-1] && (dy < MW'(ch));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lsc_pkg::ST_IDLE: begin
        if (in_valid) state_next = lsc_pkg::ST_DECODE;
      end
      lsc_pkg::ST_DECODE: begin
        if (item.action == lsc_pkg::ACT_QUERY) begin
          state_next = lsc_pkg::ST_Q_FETCH;
        end else if ({1'b0, item.sprite_index} >= 5'(NS)) begin
          state_next = lsc_pkg::ST_DONE;
        end else if (item.action == lsc_pkg::ACT_INIT) begin
          state_next = lsc_pkg::ST_INIT_CLR;
        end else if (item.action == lsc_pkg::ACT_SHOW) begin
          state_next = lsc_pkg::ST_RM_WALK;
        end else begin
          state_next = lsc_pkg::ST_DONE;
        end
      end
      lsc_pkg::ST_INIT_CLR: begin
        if (&clr_cnt) state_next = lsc_pkg::ST_DONE;
      end
      lsc_pkg::ST_RM_WALK: begin
        if (i == count) begin
          state_next = (j >= (SW+1)'(NS)) ? lsc_pkg::ST_DONE : lsc_pkg::ST_INS_WALK;
        end
      end
      lsc_pkg::ST_INS_WALK: begin
        if (i == count) state_next = lsc_pkg::ST_DONE;
      end
      lsc_pkg::ST_Q_FETCH: begin
        if (i == count) begin
          state_next = lsc_pkg::ST_DONE;
        end else if (a_w != 6'd0 && a_h != 6'd0) begin
          state_next = lsc_pkg::ST_Q_MODX;
        end
      end
      lsc_pkg::ST_Q_MODX: begin
        if (!ctile[0] || mod_last) state_next = lsc_pkg::ST_Q_MODY;
      end
      lsc_pkg::ST_Q_MODY: begin
        if (!ctile[1] || mod_last) state_next = lsc_pkg::ST_Q_CHECK;
      end
      lsc_pkg::ST_Q_CHECK: begin
        state_next = in_range ? lsc_pkg::ST_Q_READ : lsc_pkg::ST_Q_FETCH;
      end
      lsc_pkg::ST_Q_READ: begin
        state_next = (ram_rdata != transp[lsc_pkg::COLOR_BITS-1:0]) ?
                     lsc_pkg::ST_DONE : lsc_pkg::ST_Q_FETCH;
      end
      lsc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = lsc_pkg::ST_IDLE;
      end
      default: state_next = lsc_pkg::ST_IDLE;
    endcase
  end

  // control outputs: handshake, pixel memory, list write
  always_comb begin
    in_ready   = (state == lsc_pkg::ST_IDLE);
    ram_we     = 1'b0;
    ram_addr   = {item.sprite_index[SW-1:0], item.pixel_row[DW-1:0],
                  item.pixel_col[DW-1:0]};
    ram_wdata  = item.pixel_color[lsc_pkg::COLOR_BITS-1:0];
    list_we    = 1'b0;
    list_waddr = i[SW-1:0];
    list_wdata = item.sprite_index[SW-1:0];
    case (state)
      lsc_pkg::ST_DECODE: begin
        ram_we = (item.action == lsc_pkg::ACT_WRITE) && !wr_bad &&
                 ({1'b0, item.sprite_index} < 5'(NS));
      end
      lsc_pkg::ST_INIT_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = {item.sprite_index[SW-1:0], clr_cnt};
        ram_wdata = '0;
      end
      lsc_pkg::ST_Q_CHECK: begin
        ram_addr = {cur_t, dy[DW-1:0], dx[DW-1:0]};
      end
      lsc_pkg::ST_RM_WALK: begin
        // compact the list, dropping the shown sprite
        list_we    = (i != count) && (list_rd != item.sprite_index[SW-1:0]);
        list_waddr = j[SW-1:0];
        list_wdata = list_rd;
      end
      lsc_pkg::ST_INS_WALK: begin
        // ripple insert ahead of the first entry at or below our layer
        if (i == count) begin
          list_we    = 1'b1;
          list_wdata = inserted ? carry : item.sprite_index[SW-1:0];
        end else if (inserted) begin
          list_we    = 1'b1;
          list_wdata = carry;
        end else if (a_layer <= my_layer) begin
          list_we    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      transp    <= lsc_pkg::TRANSP_RESET;
      count     <= '0;
      for (int k = 0; k < NS; k++) begin
        spr_left[k]   <= '0;
        spr_top[k]    <= '0;
        spr_width[k]  <= '0;
        spr_height[k] <= '0;
        spr_layer[k]  <= '0;
        spr_tile[k]   <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) transp <= cfg_wr_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == lsc_pkg::ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      // table updates
      if (state == lsc_pkg::ST_DECODE && item.action != lsc_pkg::ACT_QUERY &&
          {1'b0, item.sprite_index} < 5'(NS)) begin
        case (item.action)
          lsc_pkg::ACT_INIT: begin
            spr_left[item.sprite_index[SW-1:0]]   <= '0;
            spr_top[item.sprite_index[SW-1:0]]    <= '0;
            spr_width[item.sprite_index[SW-1:0]]  <=
              (item.size_w > 6'(lsc_pkg::MAX_SPRITE_DIM)) ?
              6'(lsc_pkg::MAX_SPRITE_DIM) : item.size_w;
            spr_height[item.sprite_index[SW-1:0]] <=
              (item.size_h > 6'(lsc_pkg::MAX_SPRITE_DIM)) ?
              6'(lsc_pkg::MAX_SPRITE_DIM) : item.size_h;
            spr_layer[item.sprite_index[SW-1:0]]  <= '0;
            spr_tile[item.sprite_index[SW-1:0]]   <= '0;
          end
          lsc_pkg::ACT_LAYER: begin
            spr_layer[item.sprite_index[SW-1:0]] <= item.layer_value;
            spr_tile[item.sprite_index[SW-1:0]]  <= item.tile_mode;
          end
          lsc_pkg::ACT_MOVE: begin
            spr_left[item.sprite_index[SW-1:0]] <= item.pos_x;
            spr_top[item.sprite_index[SW-1:0]]  <= item.pos_y;
          end
          default: begin
          end
        endcase
      end
      if (state == lsc_pkg::ST_RM_WALK && i == count) count <= j;
      if (state == lsc_pkg::ST_INS_WALK && i == count) count <= count + 1'b1;
    end
  end

  // list storage
  always_ff @(posedge clk) begin
    if (list_we) plist[list_waddr] <= list_wdata;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == lsc_pkg::ST_IDLE && in_valid) item <= in_data;
    if (state == lsc_pkg::ST_DONE && (!out_valid || out_ready)) out_data <= res;
    case (state)
      lsc_pkg::ST_DECODE: begin
        res.covered     <= 1'b0;
        res.winner      <= '0;
        res.shown_color <= (item.action == lsc_pkg::ACT_QUERY) ?
                           8'(transp[lsc_pkg::COLOR_BITS-1:0]) : 8'd0;
        res.status      <= (item.action == lsc_pkg::ACT_WRITE &&
                            {1'b0, item.sprite_index} < 5'(NS)) ? wr_bad : 1'b0;
        i        <= '0;
        j        <= '0;
        inserted <= 1'b0;
        clr_cnt  <= '0;
        my_layer <= a_layer;
      end
      lsc_pkg::ST_INIT_CLR: clr_cnt <= clr_cnt + 1'b1;
      lsc_pkg::ST_RM_WALK: begin
        if (i == count) begin
          i <= '0;
        end else begin
          i <= i + 1'b1;
          if (list_rd != item.sprite_index[SW-1:0]) j <= j + 1'b1;
        end
      end
      lsc_pkg::ST_INS_WALK: begin
        i <= i + 1'b1;
        if (i != count) begin
          if (inserted) begin
            carry <= list_rd;
          end else if (a_layer <= my_layer) begin
            carry    <= list_rd;
            inserted <= 1'b1;
          end
        end
      end
      lsc_pkg::ST_Q_FETCH: begin
        cur_t    <= list_rd;
        cw       <= a_w;
        ch       <= a_h;
        ctile    <= a_tile;
        dx       <= dx_c;
        dy       <= dy_c;
        mag      <= dx_c[MW-1] ? MW'(-dx_c) : MW'(dx_c);
        neg      <= dx_c[MW-1];
        rem      <= '0;
        step_cnt <= '0;
        if (i != count && (a_w == 6'd0 || a_h == 6'd0)) i <= i + 1'b1;
      end
      lsc_pkg::ST_Q_MODX, lsc_pkg::ST_Q_MODY: begin
        if ((state == lsc_pkg::ST_Q_MODX && !ctile[0]) ||
            (state == lsc_pkg::ST_Q_MODY && !ctile[1]) || mod_last) begin
          if (state == lsc_pkg::ST_Q_MODX) begin
            if (ctile[0]) dx <= MW'(mod_fin);
            // load the y axis into the remainder unit
            mag <= abs_dy;
            neg <= dy[MW-1];
          end else if (ctile[1]) begin
            dy <= MW'(mod_fin);
          end
          rem      <= '0;
          step_cnt <= '0;
        end else begin
          rem      <= rem_step;
          mag      <= {mag[MW-2:0], 1'b0};
          step_cnt <= step_cnt + 1'b1;
        end
      end
      lsc_pkg::ST_Q_CHECK: begin
        if (!in_range) i <= i + 1'b1;
      end
      lsc_pkg::ST_Q_READ: begin
        if (ram_rdata != transp[lsc_pkg::COLOR_BITS-1:0]) begin
          res.shown_color <= 8'(ram_rdata);
          res.covered     <= 1'b1;
          res.winner      <= 4'(cur_t);
        end else begin
          i <= i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (SW+1)'(NS))
    else $error("priority list overflow");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == lsc_pkg::ST_Q_CHECK || state == lsc_pkg::ST_Q_READ ||
     state == lsc_pkg::ST_Q_FETCH) |-> !ram_we)
    else $error("pixel memory written during query");

  a_cover_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.covered |->
      out_data.shown_color[lsc_pkg::COLOR_BITS-1:0] != transp[lsc_pkg::COLOR_BITS-1:0])
    else $error("covered result carries transparent color");

  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.covered && out_data.status))
    else $error("query and write status both set");

endmodule

>>> hw/rtl/lsc_ram.sv
// ----------------------------------------------------------------------------
// lsc_ram
// Generic single port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read at one address (a read during a write returns the old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the layered sprite compositor: predicts every
// result item from its own sprite table and priority list, compares each
// returned item field by field, and runs under several idle and stall mixes
// and transparent code settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 10000000;
  localparam int HOLD_LEN  = 400;
  localparam int PHASES    = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int NSPR  = lsc_pkg::MAX_SPRITES;
  localparam int DIM   = lsc_pkg::MAX_SPRITE_DIM;
  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lsc_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // stimulus control
  lsc_pkg::in_item_t pending_items[$];
  lsc_pkg::out_item_t expected_colors[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  // shadow sprite table
  logic [7:0]         shadow_transp = lsc_pkg::TRANSP_RESET;
  logic signed [15:0] spr_x [NSPR];
  logic signed [15:0] spr_y [NSPR];
  logic [5:0]         spr_w [NSPR];
  logic [5:0]         spr_h [NSPR];
  logic [7:0]         spr_lyr [NSPR];
  logic [1:0]         spr_tl [NSPR];
  logic [3:0]         front_list [NSPR];
  int                 front_cnt = 0;
  logic [7:0]         pix_mem [lsc_pkg::RAM_DEPTH];

  layered_sprite_compositor_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NSPR; i++) begin
      spr_x[i] = '0; spr_y[i] = '0; spr_w[i] = '0; spr_h[i] = '0;
      spr_lyr[i] = '0; spr_tl[i] = '0; front_list[i] = '0;
    end
    for (int i = 0; i < lsc_pkg::RAM_DEPTH; i++) pix_mem[i] = '0;
  end

  // color of one sprite at a screen point, false if none
  function automatic bit sample_sprite(int s, int px, int py, output logic [7:0] c);
    int dx, dy, w, h;
    dx = px - int'(spr_x[s]);
    dy = py - int'(spr_y[s]);
    w = int'(spr_w[s]);
    h = int'(spr_h[s]);
    c = '0;
    if (w == 0 || h == 0) return 0;
    if (spr_tl[s][0]) begin
      dx = dx % w;
      if (dx < 0) dx += w;
    end
    if (spr_tl[s][1]) begin
      dy = dy % h;
      if (dy < 0) dy += h;
    end
    if (dx < 0 || dx >= w || dy < 0 || dy >= h) return 0;
    c = pix_mem[s * DIM * DIM + dy * DIM + dx];
    return (c != shadow_transp);
  endfunction

  // move a sprite ahead of the first listed sprite on its layer or below
  function automatic void list_insert(int s);
    int pos;
    for (int i = 0; i < front_cnt; i++) begin
      if (front_list[i] == s) begin
        for (int j = i; j + 1 < front_cnt; j++) front_list[j] = front_list[j + 1];
        front_cnt--;
        break;
      end
    end
    pos = front_cnt;
    for (int i = 0; i < front_cnt; i++) begin
      if (spr_lyr[front_list[i]] <= spr_lyr[s]) begin
        pos = i;
        break;
      end
    end
    if (front_cnt >= NSPR) return;
    for (int j = front_cnt; j > pos; j--) front_list[j] = front_list[j - 1];
    front_list[pos] = s[3:0];
    front_cnt++;
  endfunction

  // apply one item to the shadow table and give its result item
  function automatic lsc_pkg::out_item_t composite(lsc_pkg::in_item_t it);
    lsc_pkg::out_item_t r;
    int s;
    logic [7:0] c;
    r = '0;
    s = int'(it.sprite_index);
    case (it.action)
      lsc_pkg::ACT_QUERY: begin
        r.shown_color = shadow_transp;
        for (int i = 0; i < front_cnt; i++) begin
          if (sample_sprite(int'(front_list[i]), int'(it.pos_x), int'(it.pos_y), c)) begin
            r.shown_color = c;
            r.covered = 1'b1;
            r.winner = front_list[i];
            break;
          end
        end
      end
      lsc_pkg::ACT_INIT: begin
        spr_w[s] = (it.size_w > 6'(DIM)) ? 6'(DIM) : it.size_w;
        spr_h[s] = (it.size_h > 6'(DIM)) ? 6'(DIM) : it.size_h;
        spr_x[s] = '0; spr_y[s] = '0; spr_lyr[s] = '0; spr_tl[s] = '0;
        for (int i = 0; i < DIM * DIM; i++)
          pix_mem[s * DIM * DIM + i] = '0;
      end
      lsc_pkg::ACT_LAYER: begin
        spr_lyr[s] = it.layer_value;
        spr_tl[s] = it.tile_mode;
      end
      lsc_pkg::ACT_SHOW: list_insert(s);
      lsc_pkg::ACT_MOVE: begin
        spr_x[s] = it.pos_x;
        spr_y[s] = it.pos_y;
      end
      lsc_pkg::ACT_WRITE: begin
        if (6'(it.pixel_col) >= spr_w[s] || 6'(it.pixel_row) >= spr_h[s])
          r.status = 1'b1;
        else
          pix_mem[s * DIM * DIM + int'(it.pixel_row) * DIM
                  + int'(it.pixel_col)] = it.pixel_color;
      end
      default: ;
    endcase
    return r;
  endfunction

  // random item, mostly aimed at a few small sprites near the origin
  function automatic lsc_pkg::in_item_t random_item();
    lsc_pkg::in_item_t it;
    int pick;
    it.action = 3'($urandom);
    it.sprite_index = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 5)) : 4'($urandom);
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.size_w = 6'($urandom);
    it.size_h = 6'($urandom);
    it.layer_value = 8'($urandom);
    it.tile_mode = 2'($urandom);
    it.pixel_col = 5'($urandom);
    it.pixel_row = 5'($urandom);
    it.pixel_color = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it.action = lsc_pkg::ACT_INIT;
      if ($urandom_range(0, 9) != 0) begin
        it.size_w = 6'($urandom_range(1, 12));
        it.size_h = 6'($urandom_range(1, 12));
      end
    end else if (pick < 12) begin
      it.action = lsc_pkg::ACT_LAYER;
      if ($urandom_range(0, 3) != 0) it.layer_value = 8'($urandom_range(0, 3));
    end else if (pick < 22) begin
      it.action = lsc_pkg::ACT_SHOW;
    end else if (pick < 32) begin
      it.action = lsc_pkg::ACT_MOVE;
      if ($urandom_range(0, 7) != 0) begin
        it.pos_x = 16'($urandom_range(0, 60) - 30);
        it.pos_y = 16'($urandom_range(0, 60) - 30);
      end
    end else if (pick < 62) begin
      it.action = lsc_pkg::ACT_WRITE;
      if ($urandom_range(0, 7) != 0) begin
        it.pixel_col = 5'($urandom_range(0, 12));
        it.pixel_row = 5'($urandom_range(0, 12));
      end
      if ($urandom_range(0, 6) == 0) it.pixel_color = shadow_transp;
    end else if (pick < 97) begin
      it.action = lsc_pkg::ACT_QUERY;
      if ($urandom_range(0, 7) != 0) begin
        it.pos_x = 16'($urandom_range(0, 80) - 40);
        it.pos_y = 16'($urandom_range(0, 80) - 40);
      end
    end else begin
      it.action = ($urandom_range(0, 1) != 0) ? ACT_BAD6 : ACT_BAD7;
    end
    return it;
  endfunction

  function automatic lsc_pkg::in_item_t make_item(logic [2:0] act, int s, int a, int b);
    lsc_pkg::in_item_t it;
    it = '0;
    it.action = act;
    it.sprite_index = 4'(s);
    case (act)
      lsc_pkg::ACT_INIT:  begin it.size_w = 6'(a); it.size_h = 6'(b); end
      lsc_pkg::ACT_LAYER: begin it.layer_value = 8'(a); it.tile_mode = 2'(b); end
      lsc_pkg::ACT_WRITE: begin
        it.pixel_col = 5'(a); it.pixel_row = 5'(b); it.pixel_color = 8'($urandom);
      end
      default:   begin it.pos_x = 16'(a); it.pos_y = 16'(b); end
    endcase
    return it;
  endfunction

  // driver: offers pending items, predicts each accepted one
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_colors.push_back(composite(in_data));
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: drives out_ready and checks each accepted result item
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result item %p", out_data);
          fail_cnt++;
        end else begin
          lsc_pkg::out_item_t e;
          e = expected_colors.pop_front();
          if (out_data.shown_color !== e.shown_color) begin
            $error("shown_color exp %0d got %0d", e.shown_color, out_data.shown_color);
            fail_cnt++;
          end
          if (out_data.covered !== e.covered) begin
            $error("covered exp %0d got %0d", e.covered, out_data.covered);
            fail_cnt++;
          end
          if (out_data.winner !== e.winner) begin
            $error("winner exp %0d got %0d", e.winner, out_data.winner);
            fail_cnt++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            fail_cnt++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_cnt > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_transp(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_transp = v;
  endtask

  // main sequence
  initial begin
    int tx_mix [PHASES];
    int rx_mix [PHASES];
    tx_mix = '{0, 66, 0, 15, 66, 0};
    rx_mix = '{0, 0, 66, 15, 66, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, clamp, zero size, tiling, reorders
    @(negedge clk);
    pending_items.push_back(make_item(lsc_pkg::ACT_QUERY, 0, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_INIT, 0, 32, 32));
    pending_items.push_back(make_item(lsc_pkg::ACT_INIT, 1, 63, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_INIT, 15, 4, 3));
    pending_items.push_back(make_item(lsc_pkg::ACT_WRITE, 0, 31, 31));
    pending_items.push_back(make_item(lsc_pkg::ACT_WRITE, 0, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_WRITE, 15, 3, 2));
    pending_items.push_back(make_item(lsc_pkg::ACT_WRITE, 15, 4, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_WRITE, 1, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_LAYER, 15, 255, 3));
    pending_items.push_back(make_item(lsc_pkg::ACT_LAYER, 1, 0, 3));
    pending_items.push_back(make_item(lsc_pkg::ACT_SHOW, 0, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_SHOW, 1, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_SHOW, 15, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_QUERY, 0, 31, 31));
    pending_items.push_back(make_item(lsc_pkg::ACT_MOVE, 15, -32768, 32767));
    pending_items.push_back(make_item(lsc_pkg::ACT_QUERY, 9, -32768 + 3, 32767 + 2));
    pending_items.push_back(make_item(lsc_pkg::ACT_QUERY, 0, 32767, -32768));
    pending_items.push_back(make_item(lsc_pkg::ACT_LAYER, 0, 255, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_SHOW, 0, 0, 0));
    pending_items.push_back(make_item(lsc_pkg::ACT_QUERY, 0, 0, 0));
    pending_items.push_back(make_item(ACT_BAD6, 3, 0, 0));
    pending_items.push_back(make_item(ACT_BAD7, 15, 0, 0));
    wait_drained();

    // random phases under different idle and stall mixes and transparent codes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_transp(8'd0);
        1: write_transp(8'd255);
        5: write_transp(8'd0);
        default: write_transp(8'($urandom));
      endcase
      @(negedge clk);
      tx_idle_pct = tx_mix[p];
      rx_stall_pct = rx_mix[p];
      for (int i = 0; i < PHASE_ITEMS; i++) pending_items.push_back(random_item());
      // long receiver hold-off while the sender keeps offering
      if (p == 5) hold_req = 1'b1;
      wait_drained();
    end

    if (fail_cnt == 0 && expected_colors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_ram.sv
hw/rtl/layered_sprite_compositor_unit.sv
tb/sv/tb.sv
